>>> rtl/scfd_pkg.sv
// Shared types and constants for the sum-checked frame deframer.
// Used by scfd_step, the top level and the port checker.
`default_nettype none

package scfd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 8'd1;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd170;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd85;

    typedef enum logic [2:0] {
        PH_HEAD1 = 3'd0,
        PH_HEAD2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_ID    = 3'd3,
        PH_DATA  = 3'd4
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD      = 2'd2,
        KIND_ZERO_LEN = 2'd3
    } t_kind;

    typedef struct packed {
        t_phase             phase;
        logic [BYTE_W-1:0]  frame_length;
        logic [BYTE_W-1:0]  current_id;
        logic [BYTE_W-1:0]  running_sum;
        logic [BYTE_W-1:0]  bytes_seen;
    } t_frame_state;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  frame_id;
        logic [BYTE_W-1:0]  payload_byte;
        logic [BYTE_W-1:0]  payload_index;
        logic [BYTE_W-1:0]  payload_count;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/scfd_step.sv
// Frame parser step: next frame state and optional result for one byte.
// Purely combinational; depends on scfd_pkg.
`default_nettype none

module scfd_step (
    input  scfd_pkg::t_frame_state      i_state,
    input  logic [scfd_pkg::BYTE_W-1:0] i_byte,
    input  logic [scfd_pkg::BYTE_W-1:0] i_header_first,
    input  logic [scfd_pkg::BYTE_W-1:0] i_header_second,
    output scfd_pkg::t_frame_state      o_state,
    output logic                        o_res_valid,
    output scfd_pkg::t_result           o_result
);
    import scfd_pkg::*;

    logic [BYTE_W-1:0] count;
    logic [BYTE_W-1:0] sum_plus;

    assign count    = i_state.frame_length - 8'd1;
    assign sum_plus = i_state.running_sum + i_byte;

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_result    = '{kind: KIND_PAYLOAD, frame_id: '0, payload_byte: '0,
                        payload_index: '0, payload_count: '0, last: 1'b0};
        unique case (i_state.phase)
            PH_HEAD2: begin
                if (i_byte == i_header_second) begin
                    o_state.running_sum = sum_plus;
                    o_state.phase       = PH_LEN;
                end else begin
                    o_state.phase = PH_HEAD1;
                end
            end
            PH_LEN: begin
                if (i_byte == '0) begin
                    o_state.phase   = PH_HEAD1;
                    o_res_valid     = 1'b1;
                    o_result.kind   = KIND_ZERO_LEN;
                    o_result.last   = 1'b1;
                end else begin
                    o_state.frame_length = i_byte;
                    o_state.running_sum  = sum_plus;
                    o_state.phase        = PH_ID;
                end
            end
            PH_ID: begin
                o_state.current_id  = i_byte;
                o_state.running_sum = sum_plus;
                o_state.bytes_seen  = '0;
                o_state.phase       = PH_DATA;
            end
            PH_DATA: begin
                o_res_valid            = 1'b1;
                o_result.frame_id      = i_state.current_id;
                o_result.payload_count = count;
                if (i_state.bytes_seen < count) begin
                    o_result.payload_byte  = i_byte;
                    o_result.payload_index = i_state.bytes_seen;
                    o_state.running_sum    = sum_plus;
                    o_state.bytes_seen     = i_state.bytes_seen + 8'd1;
                end else begin
                    // Checksum byte closes the frame.
                    o_result.kind = (i_byte == i_state.running_sum) ? KIND_GOOD : KIND_BAD;
                    o_result.last = 1'b1;
                    o_state.phase = PH_HEAD1;
                end
            end
            default: begin
                // Hunting; unused phase codes behave the same way.
                o_state.phase = PH_HEAD1;
                if (i_byte == i_header_first) begin
                    o_state.running_sum = i_byte;
                    o_state.phase       = PH_HEAD2;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/sum_checked_frame_deframer_core.sv
// Each byte's result passes through the input register and then the result register.
// Throughput: one byte per cycle; the input register and the result register each
// advance whenever the stage ahead is free, so output stalls only back up the pipe.
// Bytes that produce no result still pass through the input register.
// Reset (synchronous, active low) returns to hunting the first header byte, clears
// the running sum and counters, empties both registers and restores header values.
`default_nettype none

module sum_checked_frame_deframer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte input channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [scfd_pkg::BYTE_W-1:0]    i_rx_byte,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [scfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [scfd_pkg::BYTE_W-1:0]    i_cfg_data,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [scfd_pkg::KIND_W-1:0]    o_kind,
    output logic [scfd_pkg::BYTE_W-1:0]    o_frame_id,
    output logic [scfd_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic [scfd_pkg::BYTE_W-1:0]    o_payload_index,
    output logic [scfd_pkg::BYTE_W-1:0]    o_payload_count,
    output logic                           o_last
);
    import scfd_pkg::*;

    logic [BYTE_W-1:0] r_header_first;
    logic [BYTE_W-1:0] r_header_second;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    t_frame_state      r_state;
    t_frame_state      n_state;
    logic              w_res_valid;
    t_result           w_result;

    logic              r_out_valid;
    t_result           r_result;

    logic              w_advance;
    logic              w_accept;

    assign o_cfg_ready = 1'b1;

    // The held byte moves on whenever the result register can take a result.
    assign w_advance = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_accept  = i_valid && o_ready;

    scfd_step u_step (
        .i_state         (r_state),
        .i_byte          (r_in_byte),
        .i_header_first  (r_header_first),
        .i_header_second (r_header_second),
        .o_state         (n_state),
        .o_res_valid     (w_res_valid),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= HEADER_FIRST_RST;
            r_header_second <= HEADER_SECOND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEADER_FIRST:  r_header_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_header_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_HEAD1, frame_length: '0, current_id: '0,
                         running_sum: '0, bytes_seen: '0};
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_res_valid) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_result.kind;
    assign o_frame_id      = r_result.frame_id;
    assign o_payload_byte  = r_result.payload_byte;
    assign o_payload_index = r_result.payload_index;
    assign o_payload_count = r_result.payload_count;
    assign o_last          = r_result.last;

endmodule

`default_nettype wire

>>> rtl/scfd_checker.sv
// Port-level checks for the deframer core, attached by the bind at the end.
// Depends on scfd_pkg for the result kind codes.
`default_nettype none

module scfd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [scfd_pkg::KIND_W-1:0]    o_kind,
    input  logic [scfd_pkg::BYTE_W-1:0]    o_frame_id,
    input  logic [scfd_pkg::BYTE_W-1:0]    o_payload_byte,
    input  logic [scfd_pkg::BYTE_W-1:0]    o_payload_index,
    input  logic [scfd_pkg::BYTE_W-1:0]    o_payload_count,
    input  logic                           o_last
);
    import scfd_pkg::*;

    // A stalled result must hold still until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_payload_byte) && $stable(o_payload_index) && $stable(o_last))
        else $error("stalled result changed");

    // Payload results never close a frame; every other kind does, with no byte attached.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_kind != KIND_PAYLOAD)))
        else $error("last flag disagrees with kind");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_PAYLOAD |-> o_payload_byte == '0
            && o_payload_index == '0)
        else $error("frame-end result carries payload fields");

    // Payload positions stay inside the announced count.
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_PAYLOAD |-> o_payload_index < o_payload_count)
        else $error("payload index beyond payload count");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ZERO_LEN |-> o_frame_id == '0
            && o_payload_count == '0)
        else $error("zero length error with non-zero fields");

endmodule

bind sum_checked_frame_deframer_core scfd_checker u_scfd_checker (.*);

`default_nettype wire
